@@ hw/rtl/msp_pkg.sv @@
package msp_pkg;

  localparam int NUM_STACKS_DEF = 4;
  localparam int POOL_SLOTS_DEF = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int KIND_W   = 1;
  localparam int INDEX_W  = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH = 1'b0;
  localparam logic [KIND_W-1:0] KIND_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [INDEX_W-1:0]        stack_index;
    logic signed [VALUE_W-1:0] push_value;
  } op_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] pop_value;
  } res_t;

endpackage

@@ hw/rtl/msp_if.sv @@
interface msp_req_if;
  import msp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic [INDEX_W-1:0]        stack_index;
  logic signed [VALUE_W-1:0] push_value;

  modport source (output valid, output kind, output stack_index, output push_value,
                  input ready);
  modport sink   (input valid, input kind, input stack_index, input push_value,
                  output ready);
endinterface

interface msp_rsp_if;
  import msp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] pop_value;

  modport source (output valid, output status, output pop_value, input ready);
  modport sink   (input valid, input status, input pop_value, output ready);
endinterface

@@ hw/rtl/msp_engine.sv @@
module msp_engine #(
  parameter int NUM_STACKS = msp_pkg::NUM_STACKS_DEF,
  parameter int POOL_SLOTS = msp_pkg::POOL_SLOTS_DEF,
  parameter int DATA_WIDTH = msp_pkg::DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  msp_pkg::op_t op,
  output msp_pkg::res_t res
);
  import msp_pkg::*;

  localparam int SW  = $clog2(POOL_SLOTS);
  localparam int PW  = $clog2(POOL_SLOTS + 1);
  localparam int SIW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int CW  = (SIW > INDEX_W) ? SIW : INDEX_W;
  localparam logic [PW-1:0] NULL_PTR = PW'(POOL_SLOTS);

  logic [DATA_WIDTH-1:0] slot_data [POOL_SLOTS];
  logic [PW-1:0]         slot_link [POOL_SLOTS];
  logic [PW-1:0]         stack_top [NUM_STACKS];
  logic [PW-1:0]         free_head;
  // slots at or above fill_count were never allocated; next free is slot + 1
  logic [PW-1:0]         fill_count;

  logic [CW-1:0]                sidx_w;
  logic                         in_range;
  logic [SIW-1:0]               sidx;
  logic [PW-1:0]                cur_top;
  logic                         is_push;
  logic                         push_ok;
  logic                         pop_ok;
  logic                         fresh;
  logic [SW-1:0]                link_addr;
  logic [PW-1:0]                link_rd;
  logic [PW-1:0]                next_free;
  logic signed [DATA_WIDTH-1:0] rd_data;

  always_comb begin
    sidx_w    = CW'(op.stack_index);
    in_range  = int'(sidx_w) < NUM_STACKS;
    sidx      = sidx_w[SIW-1:0];
    cur_top   = in_range ? stack_top[sidx] : NULL_PTR;
    is_push   = op.kind == KIND_PUSH;
    push_ok   = is_push && in_range && (free_head != NULL_PTR);
    pop_ok    = !is_push && (cur_top != NULL_PTR);
    fresh     = free_head == fill_count;
    link_addr = is_push ? free_head[SW-1:0] : cur_top[SW-1:0];
    link_rd   = slot_link[link_addr];
    next_free = fresh ? free_head + PW'(1) : link_rd;
    rd_data   = slot_data[cur_top[SW-1:0]];

    if (is_push) begin
      res.status = push_ok ? STATUS_OK : STATUS_FULL;
    end else begin
      res.status = pop_ok ? STATUS_OK : STATUS_EMPTY;
    end
    res.pop_value = pop_ok ? VALUE_W'(rd_data) : '0;
  end

  always_ff @(posedge clk) begin
    if (fire && push_ok) begin
      slot_data[link_addr] <= DATA_WIDTH'($unsigned(op.push_value));
      slot_link[link_addr] <= cur_top;
    end else if (fire && pop_ok) begin
      slot_link[link_addr] <= free_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head  <= '0;
      fill_count <= '0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        stack_top[i] <= NULL_PTR;
      end
    end else if (fire && push_ok) begin
      free_head       <= next_free;
      stack_top[sidx] <= free_head;
      if (fresh) begin
        fill_count <= fill_count + PW'(1);
      end
    end else if (fire && pop_ok) begin
      free_head       <= cur_top;
      stack_top[sidx] <= link_rd;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= NULL_PTR)
    else $error("fill count beyond pool size");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    free_head <= fill_count)
    else $error("free head points past allocated region");

  a_push_top: assert property (@(posedge clk) disable iff (rst)
    fire && push_ok |=> stack_top[$past(sidx)] == $past(free_head))
    else $error("push did not install free head as stack top");

  a_pop_free: assert property (@(posedge clk) disable iff (rst)
    fire && pop_ok |=> free_head == $past(cur_top))
    else $error("pop did not return slot to free list");

  a_full_only_empty_pool: assert property (@(posedge clk) disable iff (rst)
    fire && is_push && in_range && !push_ok |-> fill_count == NULL_PTR)
    else $error("pool full reported with unallocated slots left");
`endif

endmodule

@@ hw/rtl/multi_stack_shared_pool.sv @@
// Pipeline: an accepted transaction is held in the s1 register, and its result is
//   registered into the output register once the output can take it (rsp.ready).
// Throughput: one transaction per cycle while rsp.ready does not stall the output;
//   every operation touches a fixed few register entries in a single pass between the input and result registers.
// Reset (rst, synchronous): pipeline emptied, all stacks empty, free list restarted
//   at slot 0; slot contents are undefined until pushed.
module multi_stack_shared_pool #(
  parameter int NUM_STACKS = msp_pkg::NUM_STACKS_DEF,
  parameter int POOL_SLOTS = msp_pkg::POOL_SLOTS_DEF,
  parameter int DATA_WIDTH = msp_pkg::DATA_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst,
  msp_req_if.sink   req,
  msp_rsp_if.source rsp
);
  import msp_pkg::*;

  logic s1_valid;
  op_t  s1_op;
  logic out_valid;
  res_t out_res;
  res_t res;
  logic out_take;
  logic fire;
  logic req_take;

  assign out_take  = !out_valid || rsp.ready;
  assign fire      = s1_valid && out_take;
  assign req.ready = !s1_valid || fire;
  assign req_take  = req.valid && req.ready;

  msp_engine #(
    .NUM_STACKS(NUM_STACKS),
    .POOL_SLOTS(POOL_SLOTS),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_engine (
    .clk (clk),
    .rst (rst),
    .fire(fire),
    .op  (s1_op),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req_take) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
      if (out_take) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_op.kind        <= req.kind;
      s1_op.stack_index <= req.stack_index;
      s1_op.push_value  <= req.push_value;
    end
    if (fire) begin
      out_res <= res;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_res.status;
  assign rsp.pop_value = out_res.pop_value;

endmodule
